// ===== design/olid_pkg.sv =====
// ============================================================================
// olid_pkg
// Types, codes and constants shared by the ordered list insert/delete core.
// ============================================================================
package olid_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 7;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 24;
  localparam int CFG_IDX_W    = 1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SORTED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_REPEATS = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } olid_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } olid_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic load_out;
  } olid_cmd_t;

  typedef struct packed {
    logic finish;
  } olid_sts_t;

endpackage

// ===== design/olid_ctrl.sv =====
// ============================================================================
// olid_ctrl
// Operation sequencer: accepts one item, runs the list pass, hands the result
// to the output register.
// ============================================================================
module olid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_tvalid_i,
  output logic                in_tready_o,
  output logic                out_tvalid_o,
  input  logic                out_tready_i,
  output olid_pkg::olid_cmd_t cmd_o,
  input  olid_pkg::olid_sts_t sts_i
);
  import olid_pkg::*;

  olid_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.finish) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_tready_o = 1'b1;
        cmd_o.start = in_tvalid_i;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_DONE: begin
        cmd_o.load_out = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/olid_dp.sv =====
// ============================================================================
// olid_dp
// List datapath: entry memory, fill count, search, shift and compaction pass.
// ============================================================================
module olid_dp #(
  parameter int CAPACITY = olid_pkg::DEF_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  olid_pkg::olid_cmd_t              cmd_i,
  output olid_pkg::olid_sts_t              sts_o,
  input  logic                             keep_sorted_i,
  input  logic                             allow_repeats_i,
  input  logic                             func_i,
  input  logic signed [olid_pkg::VAL_W-1:0] value_i,
  output olid_pkg::olid_status_e           status_o,
  output logic [olid_pkg::CNT_W-1:0]       removed_count_o,
  output logic [olid_pkg::CNT_W-1:0]       entry_count_o,
  output logic                             is_empty_o
);
  import olid_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic [CW-1:0]    lim_q, lim_d;
  logic [CW-1:0]    removed_q, removed_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic             pv_q, pv_d;
  logic             found_q, found_d;
  logic             run_q, run_d;
  logic             func_q, func_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] carry_q, carry_d;
  olid_status_e     res_q, res_d;

  olid_status_e     status_q;
  logic [CNT_W-1:0] removed_out_q;
  logic [CNT_W-1:0] count_out_q;
  logic             empty_q;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    keep_addr;
  logic             full, ge, eq, finish;

  assign raddr     = rd_idx_q[AW-1:0];
  assign keep_addr = CW'(pidx_q) - removed_q;
  assign full      = (fill_q == CW'(CAPACITY));
  assign ge        = $signed(rdata_q) >= $signed(val_q);
  assign eq        = (rdata_q == val_q);

  always_comb begin
    fill_d    = fill_q;
    rd_idx_d  = rd_idx_q;
    lim_d     = lim_q;
    removed_d = removed_q;
    pidx_d    = pidx_q;
    pv_d      = pv_q;
    found_d   = found_q;
    run_d     = run_q;
    func_d    = func_q;
    val_d     = val_q;
    carry_d   = carry_q;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = pidx_q;
    wdata     = carry_q;
    finish    = 1'b0;

    if (cmd_i.start) begin
      rd_idx_d  = '0;
      pv_d      = 1'b0;
      found_d   = 1'b0;
      run_d     = 1'b0;
      removed_d = '0;
      func_d    = func_i;
      val_d     = value_i;
      if (func_i == FUNC_INSERT && !keep_sorted_i && allow_repeats_i) begin
        lim_d = '0;
      end else begin
        lim_d = fill_q;
      end
    end else if (cmd_i.scan) begin
      if (rd_idx_q < lim_q) begin
        pv_d     = 1'b1;
        pidx_d   = rd_idx_q[AW-1:0];
        rd_idx_d = rd_idx_q + 1'b1;
      end else begin
        pv_d = 1'b0;
      end

      if (pv_q) begin
        if (func_q == FUNC_INSERT) begin
          if (!found_q) begin
            if (keep_sorted_i ? ge : (eq && !allow_repeats_i)) begin
              if (eq && !allow_repeats_i) begin
                finish = 1'b1;
                res_d  = ST_DUP;
              end else if (full) begin
                finish = 1'b1;
                res_d  = ST_FULL;
              end else begin
                we      = 1'b1;
                wdata   = val_q;
                found_d = 1'b1;
                carry_d = rdata_q;
              end
            end
          end else begin
            we      = 1'b1;
            wdata   = carry_q;
            carry_d = rdata_q;
          end
        end else begin
          if (!found_q) begin
            if (keep_sorted_i ? ge : eq) begin
              if (eq) begin
                found_d   = 1'b1;
                removed_d = CW'(1);
                run_d     = 1'b1;
              end else begin
                finish = 1'b1;
                res_d  = ST_NOT_FOUND;
              end
            end
          end else if (allow_repeats_i && eq && (run_q || !keep_sorted_i)) begin
            removed_d = removed_q + 1'b1;
          end else begin
            we    = 1'b1;
            waddr = keep_addr[AW-1:0];
            wdata = rdata_q;
            run_d = 1'b0;
          end
        end
      end else if (rd_idx_q >= lim_q) begin
        finish = 1'b1;
        if (func_q == FUNC_INSERT) begin
          if (!found_q && full) begin
            res_d = ST_FULL;
          end else begin
            we     = 1'b1;
            waddr  = fill_q[AW-1:0];
            wdata  = found_q ? carry_q : val_q;
            fill_d = fill_q + 1'b1;
            res_d  = ST_DONE;
          end
        end else begin
          if (!found_q) begin
            res_d = ST_NOT_FOUND;
          end else begin
            fill_d = fill_q - removed_q;
            res_d  = ST_DONE;
          end
        end
      end

      if (finish) begin
        pv_d = 1'b0;
      end
    end
  end

  assign sts_o.finish = finish;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    lim_q     <= lim_d;
    removed_q <= removed_d;
    pidx_q    <= pidx_d;
    func_q    <= func_d;
    val_q     <= val_d;
    carry_q   <= carry_d;
    res_q     <= res_d;
    if (cmd_i.load_out) begin
      status_q      <= res_q;
      removed_out_q <= CNT_W'(removed_q);
      count_out_q   <= CNT_W'(fill_q);
      empty_q       <= (fill_q == '0);
    end
  end

  assign status_o        = status_q;
  assign removed_count_o = removed_out_q;
  assign entry_count_o   = count_out_q;
  assign is_empty_o      = empty_q;

endmodule

// ===== design/ordered_list_insert_delete_core.sv =====
// ============================================================================
// ordered_list_insert_delete_core
// Bounded list of signed 32-bit values with sorted or arrival ordering and a
// duplicate policy, driven by insert and delete commands.
// ============================================================================
// One command is worked at a time. After the input transfer the core walks
// the stored entries once through an entry memory with one read and one write
// port, one entry per cycle, searching and shifting or compacting in the same
// pass; a reject, a miss in sorted order or an append in arrival order with
// repeats ends early. The finished result sits in an output register, and the
// next command is taken while it waits for its transfer.
module ordered_list_insert_delete_core #(
  parameter int CAPACITY = olid_pkg::DEF_CAPACITY
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: func (1), value (32), zero fill.
  input  logic [olid_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0: status (2), removed_count (7), entry_count (7),
  // is_empty (1), zero fill.
  output logic [olid_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [olid_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic                                  cfg_wdata_i
);
  import olid_pkg::*;

  logic             keep_sorted_q, keep_sorted_d;
  logic             allow_repeats_q, allow_repeats_d;
  olid_cmd_t        cmd;
  olid_sts_t        sts;
  olid_status_e     status;
  logic [CNT_W-1:0] removed_count;
  logic [CNT_W-1:0] entry_count;
  logic             is_empty;

  always_comb begin
    keep_sorted_d   = keep_sorted_q;
    allow_repeats_d = allow_repeats_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEEP_SORTED:   keep_sorted_d   = cfg_wdata_i;
        REG_ALLOW_REPEATS: allow_repeats_d = cfg_wdata_i;
        default: begin
          keep_sorted_d = keep_sorted_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_sorted_q   <= 1'b0;
      allow_repeats_q <= 1'b1;
    end else begin
      keep_sorted_q   <= keep_sorted_d;
      allow_repeats_q <= allow_repeats_d;
    end
  end

  olid_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_o  (s_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  olid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .keep_sorted_i   (keep_sorted_q),
    .allow_repeats_i (allow_repeats_q),
    .func_i          (s_axis_tdata[0]),
    .value_i         (s_axis_tdata[VAL_W:1]),
    .status_o        (status),
    .removed_count_o (removed_count),
    .entry_count_o   (entry_count),
    .is_empty_o      (is_empty)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 17)'(0), is_empty, entry_count, removed_count,
                         status};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_removed_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_DONE) |-> (m_axis_tdata[8:2] == '0))
    else $error("nonzero removed count on a command that was not done");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (CAPACITY < 128) |-> (m_axis_tdata[16] == (m_axis_tdata[15:9] == '0)))
    else $error("empty flag disagrees with the entry count");

endmodule
